>>> hdl/gfc_pkg.sv
package gfc_pkg;

  // Fixed sizes of the block
  localparam int WeightBits   = 24;
  localparam int MaxDevices   = 16;
  localparam int IndexBits    = 4;
  localparam int CountBits    = 5;
  localparam int AlphaBits    = 9;
  localparam int TimeBits     = 16;
  localparam int QuantBits    = 16;
  localparam int WaitBits     = 17;
  localparam int CfgIndexBits = 3;
  localparam int CfgDataBits  = 16;

  // Quantiser divider: numerator is 2*|f| + q, one bit per step
  localparam int DivSteps   = WeightBits + 1;
  localparam int DivCntBits = $clog2(DivSteps);
  localparam int DvsrBits   = QuantBits + 1;

  // Filter product widths
  localparam int ProdBits  = WeightBits + AlphaBits + 1;
  localparam int ScaleBits = DivSteps + QuantBits;

  localparam logic [AlphaBits-1:0] AlphaOne  = AlphaBits'(256);
  localparam int                   FiltRound = 128;

  // Action codes of the input word
  localparam logic [1:0] ACT_HEARTBEAT = 2'd0;
  localparam logic [1:0] ACT_BEGIN     = 2'd1;
  localparam logic [1:0] ACT_ABORT     = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIndexBits-1:0] CFG_ALPHA       = 3'd0;
  localparam logic [CfgIndexBits-1:0] CFG_QUANTUM     = 3'd1;
  localparam logic [CfgIndexBits-1:0] CFG_STABILITY   = 3'd2;
  localparam logic [CfgIndexBits-1:0] CFG_CLOSURE     = 3'd3;
  localparam logic [CfgIndexBits-1:0] CFG_VALVE_COUNT = 3'd4;
  localparam logic [CfgIndexBits-1:0] CFG_PUMP_COUNT  = 3'd5;

  // Configuration reset values
  localparam logic [AlphaBits-1:0] AlphaReset     = 9'd102;
  localparam logic [QuantBits-1:0] QuantumReset   = 16'd36;
  localparam logic [TimeBits-1:0]  StabilityReset = 16'd500;
  localparam logic [TimeBits-1:0]  ClosureReset   = 16'd1000;

  // Fill phase as reported
  typedef enum logic [2:0] {
    PH_READY     = 3'd0,
    PH_STABILISE = 3'd1,
    PH_DISPENSE  = 3'd2,
    PH_CLOSURE   = 3'd3,
    PH_FINISHED  = 3'd4
  } phase_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_SUM,
    ST_PREP,
    ST_DIV,
    ST_SCALE,
    ST_ROUND,
    ST_UPDATE
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic mul_a;
    logic mul_b;
    logic sum;
    logic prep;
    logic div_step;
    logic scale;
    logic round;
    logic update;
  } gfc_cmd_t;

  typedef struct packed {
    logic sample;
    logic div_last;
  } gfc_status_t;

endpackage

>>> hdl/gravimetric_fill_controller_unit.sv
// A heartbeat with a sample passes through the multiply, sum and prepare states, the
// 25-step serial divider of the quantiser, and the scale and round states before its
// result word is written; any other word goes straight to the update. One word is
// taken at a time; the next is taken while a result word still waits at the output.
// Reset (rst, synchronous, active high) restores the register defaults, clears the
// filter, tare, target and wait counter and returns the phase to ready.
module gravimetric_fill_controller_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration port
  input  logic                                  cfg_we,
  input  logic [gfc_pkg::CfgIndexBits-1:0]      cfg_index,
  input  logic [gfc_pkg::CfgDataBits-1:0]       cfg_data,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            action,
  input  logic signed [gfc_pkg::WeightBits-1:0] raw_weight,
  input  logic                                  sample_valid,
  input  logic                                  tick,
  input  logic [gfc_pkg::IndexBits-1:0]         device_index,
  input  logic                                  use_pump,
  input  logic [gfc_pkg::WeightBits-2:0]        target_weight,
  // output channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [2:0]                            phase,
  output logic signed [gfc_pkg::WeightBits-1:0] weight,
  output logic                                  drive_on,
  output logic [gfc_pkg::IndexBits-1:0]         drive_index,
  output logic                                  drive_is_pump,
  output logic                                  dispense_done,
  output logic signed [gfc_pkg::WeightBits-1:0] done_weight,
  output logic                                  rejected
);

  gfc_pkg::gfc_cmd_t    cmd;
  gfc_pkg::gfc_status_t status;

  // Sequencer
  gfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Filter, quantiser and fill state
  gfc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .action        (action),
    .raw_weight    (raw_weight),
    .sample_valid  (sample_valid),
    .tick          (tick),
    .device_index  (device_index),
    .use_pump      (use_pump),
    .target_weight (target_weight),
    .cmd           (cmd),
    .status        (status),
    .phase         (phase),
    .weight        (weight),
    .drive_on      (drive_on),
    .drive_index   (drive_index),
    .drive_is_pump (drive_is_pump),
    .dispense_done (dispense_done),
    .done_weight   (done_weight),
    .rejected      (rejected)
  );

endmodule

>>> hdl/gfc_ctrl.sv
module gfc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  gfc_pkg::gfc_status_t status,
  output gfc_pkg::gfc_cmd_t    cmd
);

  gfc_pkg::ctrl_state_t state, state_next;
  logic                 out_valid_next;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gfc_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      gfc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.sample ? gfc_pkg::ST_MUL_A : gfc_pkg::ST_UPDATE;
        end
      end
      gfc_pkg::ST_MUL_A: begin
        cmd.mul_a  = 1'b1;
        state_next = gfc_pkg::ST_MUL_B;
      end
      gfc_pkg::ST_MUL_B: begin
        cmd.mul_b  = 1'b1;
        state_next = gfc_pkg::ST_SUM;
      end
      gfc_pkg::ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = gfc_pkg::ST_PREP;
      end
      gfc_pkg::ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = gfc_pkg::ST_DIV;
      end
      gfc_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = gfc_pkg::ST_SCALE;
      end
      gfc_pkg::ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = gfc_pkg::ST_ROUND;
      end
      gfc_pkg::ST_ROUND: begin
        cmd.round  = 1'b1;
        state_next = gfc_pkg::ST_UPDATE;
      end
      gfc_pkg::ST_UPDATE: begin
        // wait for the output register to free up
        if (!out_valid || !out_stall) begin
          cmd.update = 1'b1;
          state_next = gfc_pkg::ST_IDLE;
        end
      end
      default: state_next = gfc_pkg::ST_IDLE;
    endcase
  end

  // Result word handshake
  always_comb begin
    if (cmd.update)     out_valid_next = 1'b1;
    else if (out_stall) out_valid_next = out_valid;
    else                out_valid_next = 1'b0;
  end

endmodule

>>> hdl/gfc_dp.sv
module gfc_dp (
  input  logic                                     clk,
  input  logic                                     rst,
  // configuration
  input  logic                                     cfg_we,
  input  logic [gfc_pkg::CfgIndexBits-1:0]         cfg_index,
  input  logic [gfc_pkg::CfgDataBits-1:0]          cfg_data,
  // input word
  input  logic [1:0]                               action,
  input  logic signed [gfc_pkg::WeightBits-1:0]    raw_weight,
  input  logic                                     sample_valid,
  input  logic                                     tick,
  input  logic [gfc_pkg::IndexBits-1:0]            device_index,
  input  logic                                     use_pump,
  input  logic [gfc_pkg::WeightBits-2:0]           target_weight,
  // sequencing
  input  gfc_pkg::gfc_cmd_t                        cmd,
  output gfc_pkg::gfc_status_t                     status,
  // result word
  output logic [2:0]                               phase,
  output logic signed [gfc_pkg::WeightBits-1:0]    weight,
  output logic                                     drive_on,
  output logic [gfc_pkg::IndexBits-1:0]            drive_index,
  output logic                                     drive_is_pump,
  output logic                                     dispense_done,
  output logic signed [gfc_pkg::WeightBits-1:0]    done_weight,
  output logic                                     rejected
);

  localparam int W  = gfc_pkg::WeightBits;
  localparam int PW = gfc_pkg::ProdBits;
  localparam int NB = gfc_pkg::DivSteps;
  localparam int DB = gfc_pkg::DvsrBits;
  localparam int QW = gfc_pkg::ScaleBits;

  localparam logic signed [W-1:0] WMax = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMin = {1'b1, {(W-1){1'b0}}};

  // Configuration registers
  logic [gfc_pkg::AlphaBits-1:0] alpha_q8;
  logic [gfc_pkg::QuantBits-1:0] weight_quantum;
  logic [gfc_pkg::TimeBits-1:0]  stability_ms;
  logic [gfc_pkg::TimeBits-1:0]  closure_ms;
  logic [gfc_pkg::CountBits-1:0] valve_count;
  logic [gfc_pkg::CountBits-1:0] pump_count;

  // Fill state
  gfc_pkg::phase_t                 phase_reg;
  logic signed [W-1:0]             filtered_weight;
  logic signed [W-1:0]             latest_weight;
  logic signed [W-1:0]             tare_offset;
  logic [W-2:0]                    target_reg;
  logic [gfc_pkg::IndexBits-1:0]   device_reg;
  logic                            pump_selected;
  logic [gfc_pkg::WaitBits-1:0]    wait_count;

  // Held input word
  logic [1:0]                      item_action;
  logic signed [W-1:0]             item_raw;
  logic                            item_tick;
  logic [gfc_pkg::IndexBits-1:0]   item_index;
  logic                            item_pump;
  logic [W-2:0]                    item_target;

  // Arithmetic registers
  logic signed [W-1:0]             x_reg;
  logic signed [PW-1:0]            prod_a;
  logic signed [PW-1:0]            prod_b;
  logic [NB-1:0]                   num_sh;
  logic [DB-1:0]                   rem;
  logic [DB-1:0]                   dvsr;
  logic [gfc_pkg::DivCntBits-1:0]  div_cnt;
  logic                            neg;
  logic [QW-1:0]                   prod_q;

  // Effective alpha and quantum
  logic [gfc_pkg::AlphaBits-1:0]   a_eff;
  logic [gfc_pkg::AlphaBits-1:0]   b_eff;
  logic [gfc_pkg::QuantBits-1:0]   q_eff;
  assign a_eff = (alpha_q8 > gfc_pkg::AlphaOne) ? gfc_pkg::AlphaOne : alpha_q8;
  assign b_eff = gfc_pkg::AlphaOne - a_eff;
  assign q_eff = (weight_quantum == '0) ? gfc_pkg::QuantBits'(1) : weight_quantum;

  assign status.sample   = (action == gfc_pkg::ACT_HEARTBEAT) && sample_valid;
  assign status.div_last = (div_cnt == gfc_pkg::DivCntBits'(NB - 1));

  // Tare-corrected sample, saturated
  logic signed [W:0]   diff;
  logic signed [W-1:0] x_sat;
  assign diff = (W + 1)'(raw_weight) - (W + 1)'(tare_offset);
  always_comb begin
    if (diff[W] != diff[W-1]) x_sat = diff[W] ? WMin : WMax;
    else                      x_sat = diff[W-1:0];
  end

  // Filter sum plus 128, floor divide by 256
  logic signed [PW:0] acc;
  assign acc = (PW + 1)'(prod_a) + (PW + 1)'(prod_b) + (PW + 1)'(gfc_pkg::FiltRound);

  // Magnitude of the filtered value
  logic [W-1:0] mag;
  assign mag = filtered_weight[W-1] ? (~filtered_weight + 1'b1) : filtered_weight;

  // One restoring step
  logic [DB:0] rem_sh;
  logic [DB:0] rem_sub;
  logic        q_bit;
  assign rem_sh  = {rem, num_sh[NB-1]};
  assign rem_sub = rem_sh - {1'b0, dvsr};
  assign q_bit   = (rem_sh >= {1'b0, dvsr});

  // Rounded magnitude back to signed, saturated
  logic                over;
  logic signed [W-1:0] low;
  logic signed [W-1:0] rounded;
  assign over = |prod_q[QW-1:W-1];
  assign low  = {1'b0, prod_q[W-2:0]};
  always_comb begin
    if (over)     rounded = neg ? WMin : WMax;
    else if (neg) rounded = -low;
    else          rounded = low;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_q8       <= gfc_pkg::AlphaReset;
      weight_quantum <= gfc_pkg::QuantumReset;
      stability_ms   <= gfc_pkg::StabilityReset;
      closure_ms     <= gfc_pkg::ClosureReset;
      valve_count    <= '0;
      pump_count     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gfc_pkg::CFG_ALPHA:       alpha_q8       <= cfg_data[gfc_pkg::AlphaBits-1:0];
        gfc_pkg::CFG_QUANTUM:     weight_quantum <= cfg_data[gfc_pkg::QuantBits-1:0];
        gfc_pkg::CFG_STABILITY:   stability_ms   <= cfg_data[gfc_pkg::TimeBits-1:0];
        gfc_pkg::CFG_CLOSURE:     closure_ms     <= cfg_data[gfc_pkg::TimeBits-1:0];
        gfc_pkg::CFG_VALVE_COUNT: valve_count    <= cfg_data[gfc_pkg::CountBits-1:0];
        gfc_pkg::CFG_PUMP_COUNT:  pump_count     <= cfg_data[gfc_pkg::CountBits-1:0];
        default: ;
      endcase
    end
  end

  // Input word capture and arithmetic steps
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_action <= action;
      item_raw    <= raw_weight;
      item_tick   <= tick;
      item_index  <= device_index;
      item_pump   <= use_pump;
      item_target <= target_weight;
      x_reg       <= x_sat;
    end
    if (cmd.mul_a) prod_a <= $signed({1'b0, a_eff}) * x_reg;
    if (cmd.mul_b) prod_b <= $signed({1'b0, b_eff}) * filtered_weight;
    if (cmd.prep) begin
      num_sh  <= {mag, 1'b0} + NB'(q_eff);
      dvsr    <= {q_eff, 1'b0};
      rem     <= '0;
      div_cnt <= '0;
      neg     <= filtered_weight[W-1];
    end
    if (cmd.div_step) begin
      num_sh  <= {num_sh[NB-2:0], q_bit};
      rem     <= q_bit ? rem_sub[DB-1:0] : rem_sh[DB-1:0];
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd.scale) prod_q <= num_sh * q_eff;
  end

  // Fill sequencing for one word
  gfc_pkg::phase_t              ph_next;
  logic signed [W-1:0]          latest_next;
  logic [W-2:0]                 target_next;
  logic [gfc_pkg::IndexBits-1:0] dev_next;
  logic                         pump_next;
  logic [gfc_pkg::WaitBits-1:0] wait_next;
  logic                         done_next;
  logic signed [W-1:0]          done_w_next;
  logic                         rej_next;
  logic                         tare_load;
  logic [gfc_pkg::CountBits-1:0] count_sel;
  logic [gfc_pkg::CountBits-1:0] idx_ext;
  logic                         tick_eff;

  assign count_sel = item_pump ? pump_count : valve_count;
  assign idx_ext   = {1'b0, item_index};
  assign tick_eff  = (item_action == gfc_pkg::ACT_HEARTBEAT) && item_tick;

  always_comb begin
    ph_next     = phase_reg;
    latest_next = latest_weight;
    target_next = target_reg;
    dev_next    = device_reg;
    pump_next   = pump_selected;
    wait_next   = wait_count;
    done_next   = 1'b0;
    done_w_next = '0;
    rej_next    = 1'b0;
    tare_load   = 1'b0;
    case (item_action)
      gfc_pkg::ACT_BEGIN: begin
        if (idx_ext >= count_sel ||
            idx_ext >= gfc_pkg::CountBits'(gfc_pkg::MaxDevices)) begin
          rej_next = 1'b1;
        end else begin
          pump_next   = item_pump;
          dev_next    = item_index;
          tare_load   = 1'b1;
          target_next = item_target;
          wait_next   = '0;
          ph_next     = gfc_pkg::PH_STABILISE;
        end
      end
      gfc_pkg::ACT_ABORT: begin
        ph_next     = gfc_pkg::PH_FINISHED;
        target_next = '0;
        latest_next = '0;
        wait_next   = '0;
      end
      default: begin
        if (phase_reg == gfc_pkg::PH_STABILISE || phase_reg == gfc_pkg::PH_DISPENSE ||
            phase_reg == gfc_pkg::PH_CLOSURE) begin
          if (tick_eff && wait_count != '1) wait_next = wait_count + 1'b1;
          // closure time over: report and finish
          if (ph_next == gfc_pkg::PH_CLOSURE && wait_next > {1'b0, closure_ms}) begin
            done_next   = 1'b1;
            done_w_next = latest_weight;
            ph_next     = gfc_pkg::PH_FINISHED;
            target_next = '0;
            latest_next = '0;
            wait_next   = '0;
          end
          if (ph_next == gfc_pkg::PH_STABILISE && wait_next > {1'b0, stability_ms})
            ph_next = gfc_pkg::PH_DISPENSE;
          // target reached: release the device
          if (ph_next == gfc_pkg::PH_DISPENSE &&
              latest_weight >= $signed({1'b0, target_reg})) begin
            ph_next   = gfc_pkg::PH_CLOSURE;
            wait_next = '0;
          end
        end
      end
    endcase
  end

  // Fill state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg       <= gfc_pkg::PH_READY;
      filtered_weight <= '0;
      latest_weight   <= '0;
      tare_offset     <= '0;
      target_reg      <= '0;
      device_reg      <= '0;
      pump_selected   <= '0;
      wait_count      <= '0;
    end else begin
      if (cmd.sum)   filtered_weight <= acc[W+7:8];
      if (cmd.round) latest_weight   <= rounded;
      if (cmd.update) begin
        phase_reg     <= ph_next;
        latest_weight <= latest_next;
        target_reg    <= target_next;
        device_reg    <= dev_next;
        pump_selected <= pump_next;
        wait_count    <= wait_next;
        if (tare_load) tare_offset <= item_raw;
      end
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      phase         <= ph_next;
      weight        <= latest_next;
      drive_on      <= (ph_next == gfc_pkg::PH_DISPENSE);
      drive_index   <= dev_next;
      drive_is_pump <= pump_next;
      dispense_done <= done_next;
      done_weight   <= done_w_next;
      rejected      <= rej_next;
    end
  end

endmodule

>>> hdl/gfc_checker.sv
module gfc_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic [2:0]                            phase,
  input logic signed [gfc_pkg::WeightBits-1:0] weight,
  input logic                                  drive_on,
  input logic                                  dispense_done,
  input logic                                  rejected
);

  // one word in flight: busy right after an accepted word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again straight after a word");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(phase) && $stable(weight))
    else $error("result word changed under stall");

  // device driven only while dispensing
  a_drive_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive_on == (phase == gfc_pkg::PH_DISPENSE)))
    else $error("drive_on disagrees with phase");

  // done pulse only on finishing, never with a refusal
  a_done_finish: assert property (@(posedge clk) disable iff (rst)
    out_valid && dispense_done |-> (phase == gfc_pkg::PH_FINISHED) && !rejected)
    else $error("done pulse outside finish");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind gravimetric_fill_controller_unit gfc_checker u_gfc_checker (.*);

>>> tb/tb_gravimetric_fill_controller_unit.sv
module tb_gravimetric_fill_controller_unit;
  import gfc_pkg::*;

  // Action code the block leaves unused; it behaves as a bare heartbeat
  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam longint WeightMax = (longint'(1) << (WeightBits - 1)) - 1;
  localparam longint WeightMin = -(longint'(1) << (WeightBits - 1));
  localparam longint TargetMax = (longint'(1) << (WeightBits - 1)) - 1;
  localparam longint WaitMax   = (longint'(1) << WaitBits) - 1;
  localparam int     LatencyCycles = 40;
  localparam longint CycleLimit    = 800000;

  typedef struct packed {
    logic [1:0]                   act;
    logic signed [WeightBits-1:0] raw;
    logic                         smp;
    logic                         tk;
    logic [IndexBits-1:0]         idx;
    logic                         pmp;
    logic [WeightBits-2:0]        tgt;
  } fill_word_t;

  typedef struct packed {
    phase_t                       ph;
    logic signed [WeightBits-1:0] wt;
    logic                         on;
    logic [IndexBits-1:0]         didx;
    logic                         dpump;
    logic                         done;
    logic signed [WeightBits-1:0] dwt;
    logic                         rej;
  } fill_status_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [CfgIndexBits-1:0]      cfg_index = '0;
  logic [CfgDataBits-1:0]       cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [1:0]                   action = ACT_HEARTBEAT;
  logic signed [WeightBits-1:0] raw_weight = '0;
  logic                         sample_valid = 1'b0;
  logic                         tick = 1'b0;
  logic [IndexBits-1:0]         device_index = '0;
  logic                         use_pump = 1'b0;
  logic [WeightBits-2:0]        target_weight = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [2:0]                   phase;
  logic signed [WeightBits-1:0] weight;
  logic                         drive_on;
  logic [IndexBits-1:0]         drive_index;
  logic                         drive_is_pump;
  logic                         dispense_done;
  logic signed [WeightBits-1:0] done_weight;
  logic                         rejected;

  // Controller copy: settings and fill state as the block should hold them
  int unsigned          alpha_set = AlphaReset;
  int unsigned          quant_set = QuantumReset;
  int unsigned          stab_set  = StabilityReset;
  int unsigned          close_set = ClosureReset;
  int unsigned          valve_set = 0;
  int unsigned          pump_set  = 0;
  phase_t               ph_s      = PH_READY;
  longint               filt_w    = 0;
  longint               latest_w  = 0;
  longint               tare_w    = 0;
  longint               target_w  = 0;
  logic [IndexBits-1:0] dev_s     = '0;
  logic                 pump_s    = 1'b0;
  longint               wait_s    = 0;

  fill_status_t pending_status[$];
  int           send_idle_pct = 15;
  int           recv_idle_pct = 67;
  int           words_left    = 0;
  int           mismatches    = 0;
  int           results_seen  = 0;
  longint       cycles        = 0;

  gravimetric_fill_controller_unit u_top (.*);

  always #4 clk = ~clk;

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic longint clamp_weight(input longint v);
    if (v > WeightMax) return WeightMax;
    if (v < WeightMin) return WeightMin;
    return v;
  endfunction

  function automatic void end_fill();
    ph_s     = PH_FINISHED;
    target_w = 0;
    latest_w = 0;
    wait_s   = 0;
  endfunction

  // One word through the fill controller: updates the state, returns the status word
  function automatic fill_status_t advance_fill(input fill_word_t w);
    fill_status_t r;
    longint       a, x, q, mag, n, cnt;
    logic         tk;
    r = '0;
    if (w.act == ACT_BEGIN) begin
      cnt = w.pmp ? pump_set : valve_set;
      if (w.idx >= cnt || w.idx >= MaxDevices) begin
        r.rej = 1'b1;
      end else begin
        pump_s   = w.pmp;
        dev_s    = w.idx;
        tare_w   = longint'($signed(w.raw));
        target_w = longint'(w.tgt);
        wait_s   = 0;
        ph_s     = PH_STABILISE;
      end
    end else if (w.act == ACT_ABORT) begin
      end_fill();
    end else begin
      tk = (w.act == ACT_HEARTBEAT) && w.tk;
      if (w.act == ACT_HEARTBEAT && w.smp) begin
        // tare, Q8 smoothing, then round to the quantum with halves away from zero
        a      = (alpha_set > 256) ? 256 : alpha_set;
        q      = (quant_set == 0) ? 1 : quant_set;
        x      = clamp_weight(longint'($signed(w.raw)) - tare_w);
        filt_w = (a * x + (256 - a) * filt_w + 128) >>> 8;
        mag    = (filt_w < 0) ? -filt_w : filt_w;
        n      = (2 * mag + q) / (2 * q);
        latest_w = clamp_weight((filt_w < 0) ? -(n * q) : n * q);
      end
      if (ph_s >= PH_STABILISE && ph_s <= PH_CLOSURE) begin
        if (tk && wait_s < WaitMax) wait_s++;
        if (ph_s == PH_CLOSURE && wait_s > close_set) begin
          r.done = 1'b1;
          r.dwt  = latest_w[WeightBits-1:0];
          end_fill();
        end
        if (ph_s == PH_STABILISE && wait_s > stab_set) ph_s = PH_DISPENSE;
        if (ph_s == PH_DISPENSE && latest_w >= target_w) begin
          ph_s   = PH_CLOSURE;
          wait_s = 0;
        end
      end
    end
    r.ph    = ph_s;
    r.wt    = latest_w[WeightBits-1:0];
    r.on    = (ph_s == PH_DISPENSE);
    r.didx  = dev_s;
    r.dpump = pump_s;
    return r;
  endfunction

  // Result checker
  always @(posedge clk) begin : check_results
    fill_status_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_status.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected", results_seen));
      end else begin
        want = pending_status.pop_front();
        if (phase !== want.ph)
          report_mismatch($sformatf("result %0d phase got %0d want %0d",
                                    results_seen, phase, want.ph));
        if (weight !== want.wt)
          report_mismatch($sformatf("result %0d weight got %0d want %0d",
                                    results_seen, weight, $signed(want.wt)));
        if (drive_on !== want.on)
          report_mismatch($sformatf("result %0d drive_on got %0b want %0b",
                                    results_seen, drive_on, want.on));
        if (drive_index !== want.didx)
          report_mismatch($sformatf("result %0d drive_index got %0d want %0d",
                                    results_seen, drive_index, want.didx));
        if (drive_is_pump !== want.dpump)
          report_mismatch($sformatf("result %0d drive_is_pump got %0b want %0b",
                                    results_seen, drive_is_pump, want.dpump));
        if (dispense_done !== want.done)
          report_mismatch($sformatf("result %0d dispense_done got %0b want %0b",
                                    results_seen, dispense_done, want.done));
        if (done_weight !== want.dwt)
          report_mismatch($sformatf("result %0d done_weight got %0d want %0d",
                                    results_seen, done_weight, $signed(want.dwt)));
        if (rejected !== want.rej)
          report_mismatch($sformatf("result %0d rejected got %0b want %0b",
                                    results_seen, rejected, want.rej));
      end
    end
  end

  function automatic fill_word_t make_word(input logic [1:0] act, input longint raw,
                                           input logic smp, input logic tk,
                                           input logic [IndexBits-1:0] idx,
                                           input logic pmp, input longint tgt);
    fill_word_t w;
    w.act = act;
    w.raw = raw[WeightBits-1:0];
    w.smp = smp;
    w.tk  = tk;
    w.idx = idx;
    w.pmp = pmp;
    w.tgt = tgt[WeightBits-2:0];
    return w;
  endfunction

  function automatic fill_word_t random_word();
    return make_word(2'($urandom_range(0, 3)), longint'($urandom), 1'($urandom),
                     1'($urandom), IndexBits'($urandom), 1'($urandom),
                     longint'($urandom));
  endfunction

  // Present one word and wait for it to be taken; the expectation is logged on acceptance
  task automatic send_word(input fill_word_t w);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    action        <= w.act;
    raw_weight    <= w.raw;
    sample_valid  <= w.smp;
    tick          <= w.tk;
    device_index  <= w.idx;
    use_pump      <= w.pmp;
    target_weight <= w.tgt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_status = {pending_status, advance_fill(w)};
    if (w.act != ACT_SPARE && words_left > 0) words_left--;
  endtask

  // Let every outstanding word come back, then allow the pipeline to settle
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (LatencyCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexBits-1:0] index, input int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value[CfgDataBits-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_ALPHA:       alpha_set = value & ((1 << AlphaBits) - 1);
      CFG_QUANTUM:     quant_set = value & ((1 << QuantBits) - 1);
      CFG_STABILITY:   stab_set  = value & ((1 << TimeBits) - 1);
      CFG_CLOSURE:     close_set = value & ((1 << TimeBits) - 1);
      CFG_VALVE_COUNT: valve_set = value & ((1 << CountBits) - 1);
      CFG_PUMP_COUNT:  pump_set  = value & ((1 << CountBits) - 1);
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int unsigned alpha, input int unsigned quantum,
                                input int unsigned stab_ticks, input int unsigned close_ticks,
                                input int unsigned valves, input int unsigned pumps);
    write_reg(CFG_ALPHA, alpha);
    write_reg(CFG_QUANTUM, quantum);
    write_reg(CFG_STABILITY, stab_ticks);
    write_reg(CFG_CLOSURE, close_ticks);
    write_reg(CFG_VALVE_COUNT, valves);
    write_reg(CFG_PUMP_COUNT, pumps);
  endtask

  // Register defaults: no devices fitted, so every begin is refused
  task automatic test_reset_defaults();
    send_word(make_word(ACT_HEARTBEAT, WeightMax, 1, 1, 0, 0, 0));
    send_word(make_word(ACT_HEARTBEAT, WeightMin, 1, 0, 0, 0, 0));
    send_word(make_word(ACT_BEGIN, 0, 0, 0, 0, 0, 100));
    send_word(make_word(ACT_BEGIN, 'h5A5A5A, 1, 1, 15, 1, TargetMax));
    send_word(make_word(ACT_SPARE, 12345, 1, 1, 7, 1, 55));
    send_word(make_word(ACT_ABORT, -1, 1, 1, 15, 1, TargetMax));
    send_word(make_word(ACT_HEARTBEAT, 'h555555, 1, 1, 10, 0, 'h2AAAAA));
    drain_results();
  endtask

  // Full-scale weights, zero waits and the top device index of each kind
  task automatic test_full_scale();
    apply_settings(AlphaOne, 1, 0, 0, MaxDevices, MaxDevices);
    send_word(make_word(ACT_BEGIN, WeightMin, 1, 1, 15, 0, TargetMax));
    send_word(make_word(ACT_HEARTBEAT, WeightMax, 1, 0, 0, 0, 0));
    send_word(make_word(ACT_HEARTBEAT, 0, 0, 1, 0, 0, 0));
    send_word(make_word(ACT_HEARTBEAT, 0, 0, 1, 0, 0, 0));
    send_word(make_word(ACT_BEGIN, WeightMax, 0, 0, 15, 1, 0));
    send_word(make_word(ACT_HEARTBEAT, WeightMin, 1, 1, 0, 0, 0));
    // begin while dispensing restarts the fill
    send_word(make_word(ACT_BEGIN, 0, 1, 1, 0, 1, 0));
    send_word(make_word(ACT_HEARTBEAT, 0, 0, 1, 0, 0, 0));
    send_word(make_word(ACT_ABORT, 0, 0, 0, 0, 0, 0));
    drain_results();
  endtask

  // Alpha above one, zero and maximum quantum, longest waits, uneven device counts
  task automatic test_odd_settings();
    apply_settings(511, 0, 65535, 65535, 5, 31);
    send_word(make_word(ACT_BEGIN, 0, 0, 0, 5, 0, 1000));
    send_word(make_word(ACT_BEGIN, 0, 0, 0, 4, 0, 1000));
    send_word(make_word(ACT_BEGIN, 0, 0, 0, 15, 1, 1000));
    send_word(make_word(ACT_HEARTBEAT, 777, 1, 1, 0, 0, 0));
    send_word(make_word(ACT_ABORT, 0, 0, 0, 0, 0, 0));
    drain_results();
    write_reg(CFG_ALPHA, 0);
    write_reg(CFG_QUANTUM, 65535);
    // zero alpha holds the filter
    send_word(make_word(ACT_HEARTBEAT, WeightMax, 1, 0, 0, 0, 0));
    drain_results();
    write_reg(CFG_ALPHA, AlphaOne);
    // values just either side of half the quantum round to the nearer multiple
    send_word(make_word(ACT_HEARTBEAT, 32768, 1, 0, 0, 0, 0));
    send_word(make_word(ACT_HEARTBEAT, -32768, 1, 0, 0, 0, 0));
    send_word(make_word(ACT_HEARTBEAT, -32767, 1, 0, 0, 0, 0));
    send_word(make_word(ACT_HEARTBEAT, WeightMax, 1, 0, 0, 0, 0));
    drain_results();
  endtask

  // One fill from begin to done or abort, with a rising scale and odd stray words
  task automatic run_fill();
    logic                 pmp;
    logic                 broken;
    logic                 smp;
    int unsigned          cnt;
    logic [IndexBits-1:0] idx;
    longint               tare, tgt, step, lvl, raw;
    int                   beats;
    pmp    = 1'($urandom_range(0, 1));
    cnt    = pmp ? pump_set : valve_set;
    broken = (cnt == 0) || ($urandom_range(0, 9) == 0);
    if (broken) idx = IndexBits'($urandom_range(0, MaxDevices - 1));
    else idx = IndexBits'($urandom_range(0, ((cnt > MaxDevices) ? MaxDevices : cnt) - 1));
    tare = longint'($urandom_range(0, 2000000)) - 1000000;
    if ($urandom_range(0, 7) == 0) tgt = $urandom_range(0, TargetMax);
    else tgt = $urandom_range(0, 60000);
    send_word(make_word(ACT_BEGIN, tare, 1'($urandom), 1'($urandom), idx, pmp, tgt));
    step  = tgt / 6 + $urandom_range(1, 3000);
    lvl   = 0;
    beats = 0;
    while (words_left > 0 && beats < 60 && (beats < 3 || ph_s != PH_FINISHED)) begin
      beats++;
      case ($urandom_range(0, 49))
        0, 1: send_word(random_word());
        2: send_word(make_word(ACT_ABORT, longint'($urandom), 1'($urandom), 1'($urandom),
                               IndexBits'($urandom), 1'($urandom), longint'($urandom)));
        3: send_word(make_word(ACT_BEGIN, tare, 1'($urandom), 1'($urandom), idx, pmp, tgt));
        default: begin
          smp = ($urandom_range(0, 3) != 0);
          if (smp) lvl += step;
          raw = clamp_weight(tare + lvl + $urandom_range(0, 400) - 200);
          send_word(make_word(ACT_HEARTBEAT, raw, smp, $urandom_range(0, 3) != 0,
                              IndexBits'($urandom), 1'($urandom), longint'($urandom)));
        end
      endcase
    end
    if (ph_s != PH_FINISHED) send_word(make_word(ACT_ABORT, 0, 0, 0, 0, 0, 0));
  endtask

  // Random fills under a given idling pattern, with a fresh setting per round
  task automatic test_random_fills(input int send_pct, input int recv_pct);
    int unsigned alpha, quantum, stab_ticks, close_ticks, valves, pumps;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (4) begin
      drain_results();
      case ($urandom_range(0, 5))
        0:       alpha = 0;
        1:       alpha = AlphaOne;
        2:       alpha = $urandom_range(257, 511);
        default: alpha = $urandom_range(1, 255);
      endcase
      case ($urandom_range(0, 5))
        0:       quantum = 0;
        1:       quantum = 1;
        2:       quantum = 65535;
        default: quantum = $urandom_range(2, 400);
      endcase
      stab_ticks  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 6);
      close_ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 6);
      valves = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 31);
      pumps  = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 31);
      apply_settings(alpha, quantum, stab_ticks, close_ticks, valves, pumps);
      words_left = 120;
      while (words_left > 0) begin
        if ($urandom_range(0, 9) == 0) send_word(random_word());
        else run_fill();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_full_scale();
    test_odd_settings();
    test_random_fills(15, 67);
    test_random_fills(67, 15);
    test_random_fills(0, 0);
    drain_results();
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
